// ----- hw/rtl/tksk_pkg.sv -----
// ----------------------------------------------------------------------------
// tksk_pkg
// shared types, constants and codes of the top-k score keeper
// ----------------------------------------------------------------------------
package tksk_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int KEY_W      = 64;
  localparam int SCORE_W    = 54;
  localparam int KEEP_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int HALF_W     = KEY_W / 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_SEED  = 2'd2;

  // input item kinds
  localparam logic KIND_OFFER = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;
  localparam logic [KEY_W-1:0]  SEED_RESET = 64'h3a5f_2d91_c7b0_4913;

  // splitmix64 finalizer
  localparam logic [KEY_W-1:0] MIX_C1 = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [KEY_W-1:0] MIX_C2 = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [KEY_W-1:0] MIX_C3 = 64'h94d0_49bb_1331_11eb;
  localparam int MIX_SH1 = 30;
  localparam int MIX_SH2 = 27;
  localparam int MIX_SH3 = 31;
  localparam int HASH_SH = 11;

  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic signed [SCORE_W-1:0] score;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } store_wr_t;

  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] a;
    logic [KEY_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [KEY_W-1:0] product;
  } mul_rsp_t;

  typedef struct packed {
    logic above;  // a ranks above b
    logic gt;     // a score strictly greater
  } cmp_res_t;

endpackage

// ----- hw/rtl/tksk_mul.sv -----
// ----------------------------------------------------------------------------
// tksk_mul
// 64 x 64 -> low 64 multiplier built from one 32 x 32 multiplier, reused for three partial products
// ----------------------------------------------------------------------------
module tksk_mul
  import tksk_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic              busy;
  logic [1:0]        cnt;
  logic              done;
  logic [KEY_W-1:0]  a_r;
  logic [KEY_W-1:0]  b_r;
  logic [KEY_W-1:0]  prod;
  logic [KEY_W-1:0]  acc;
  logic [HALF_W-1:0] op_x;
  logic [HALF_W-1:0] op_y;

  // step 0: al*bl, step 1: al*bh, step 2: ah*bl
  always_comb begin
    op_x = cnt[1] ? a_r[KEY_W-1:HALF_W] : a_r[HALF_W-1:0];
    op_y = (cnt == 2'd1) ? b_r[KEY_W-1:HALF_W] : b_r[HALF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= 2'd0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      a_r <= req.a;
      b_r <= req.b;
    end
    prod <= op_x * op_y;
    if (busy) begin
      case (cnt)
        2'd1:    acc <= prod;
        2'd2:    acc <= acc + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
        2'd3:    acc <= acc + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
        default: acc <= acc;
      endcase
    end
  end

  assign rsp.done    = done;
  assign rsp.product = acc;

endmodule

// ----- hw/rtl/tksk_cmp.sv -----
// ----------------------------------------------------------------------------
// tksk_cmp
// rank compare: higher score first, smaller key breaks ties
// ----------------------------------------------------------------------------
module tksk_cmp
  import tksk_pkg::*;
(
  input  entry_t   a,
  input  entry_t   b,
  output cmp_res_t res
);

  logic gt;
  logic eq;

  always_comb begin
    gt        = a.score > b.score;
    eq        = a.score == b.score;
    res.gt    = gt;
    res.above = gt || (eq && (a.key < b.key));
  end

endmodule

// ----- hw/rtl/tksk_store.sv -----
// ----------------------------------------------------------------------------
// tksk_store
// entry store, one write port and one registered read port
// ----------------------------------------------------------------------------
module tksk_store
  import tksk_pkg::*;
(
  input  logic             clk,
  input  store_wr_t        wr,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hw/rtl/top_k_score_keeper_core.sv -----
// ----------------------------------------------------------------------------
// top_k_score_keeper_core
// streaming top-k keeper: holds the best scoring keys offered so far and
// emits them in rank order on a drain
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in      | in        | in_valid / in_ready  | kind, record_key, offer_score
//  out     | out       | out_valid / out_ready| out_key, out_score, out_empty,
//          |           |                      | out_last
//  cfg     | in        | cfg_we (no wait)     | cfg_index, cfg_data
//
//  offer with room in the store: appended in S_PLACE; offer against a full
//  store: S_PLACE, a scan for the weakest entry on the single rank
//  comparator, then S_REPL; hash mode first runs S_PREP, S_MUL1 and S_MUL2:
//  two 64-bit products, each from partial products of one 32 x 32 multiplier
//  drain of n entries: one store scan per rank, each followed by S_LOAD;
//  an empty drain goes straight to S_LOAD for a single empty result
//  rst (synchronous) empties the store and reloads the registers
//  a waiting result sits in the output register; the next rank is searched
//  meanwhile and loaded once that register is taken
//
module top_k_score_keeper_core
  import tksk_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        kind,
  input  logic [KEY_W-1:0]            record_key,
  input  logic signed [SCORE_W-1:0]   offer_score,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [KEY_W-1:0]            out_key,
  output logic signed [SCORE_W-1:0]   out_score,
  output logic                        out_empty,
  output logic                        out_last,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_MUL1  = 3'd2;
  localparam logic [2:0] S_MUL2  = 3'd3;
  localparam logic [2:0] S_PLACE = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_REPL  = 3'd6;
  localparam logic [2:0] S_LOAD  = 3'd7;

  logic [2:0]                state;

  // configuration
  logic [KEEP_W-1:0]         keep_count;
  logic                      hash_mode;
  logic [KEY_W-1:0]          hash_seed;

  // current item
  logic                      is_drain;
  logic                      empty_flag;
  logic [KEY_W-1:0]          cur_key;
  logic signed [SCORE_W-1:0] cur_score;

  // store bookkeeping
  logic [CNT_W-1:0]          kept_count;
  logic [CNT_W-1:0]          keep_eff;
  logic [CNT_W-1:0]          rank;
  logic [CAPACITY-1:0]       emitted;

  // scan registers
  logic [IDX_W-1:0]          scan_idx;
  logic [IDX_W-1:0]          scan_idx_next;
  logic                      have;
  logic [IDX_W-1:0]          best_idx;
  entry_t                    best;

  // shared units
  store_wr_t                 st_wr;
  entry_t                    cand;
  mul_req_t                  mreq;
  mul_rsp_t                  mrsp;
  entry_t                    cmp_a;
  entry_t                    cmp_b;
  cmp_res_t                  cmp_r;

  logic                      in_xfer;
  logic                      out_free;
  logic                      scan_last;
  logic                      take;
  logic                      load_last;
  logic [KEY_W-1:0]          mix_t;
  logic [KEY_W-1:0]          mix_h;
  logic [SCORE_W-1:0]        hash_score;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // keep count saturates at the store size
  always_comb begin
    if (int'(keep_count) > CAPACITY) begin
      keep_eff = CNT_W'(CAPACITY);
    end else begin
      keep_eff = CNT_W'(keep_count);
    end
  end

  // hash front end and back end around the shared multiplier
  always_comb begin
    mix_t      = (cur_key ^ hash_seed) + MIX_C1;
    mix_h      = mrsp.product ^ (mrsp.product >> MIX_SH3);
    hash_score = SCORE_W'(0) - {1'b0, mix_h[KEY_W-1:HASH_SH]};
  end

  always_comb begin
    mreq.start = 1'b0;
    mreq.a     = mix_t ^ (mix_t >> MIX_SH1);
    mreq.b     = MIX_C2;
    case (state)
      S_PREP: mreq.start = 1'b1;
      S_MUL1: begin
        mreq.start = mrsp.done;
        mreq.a     = mrsp.product ^ (mrsp.product >> MIX_SH2);
        mreq.b     = MIX_C3;
      end
      default: mreq.start = 1'b0;
    endcase
  end

  tksk_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  // the store read is registered, so it is addressed with the next scan index
  always_comb begin
    scan_idx_next = scan_idx;
    if (in_xfer) begin
      scan_idx_next = '0;
    end else if (state == S_SCAN && !scan_last) begin
      scan_idx_next = scan_idx + IDX_W'(1);
    end else if (state == S_LOAD && out_free && !load_last) begin
      scan_idx_next = '0;
    end
  end

  tksk_store u_store (
    .clk     (clk),
    .wr      (st_wr),
    .rd_addr (scan_idx_next),
    .rd_data (cand)
  );

  // one comparator: weakest search, best search and the replace test
  always_comb begin
    cmp_a = cand;
    cmp_b = best;
    if (state == S_REPL) begin
      cmp_a.key   = cur_key;
      cmp_a.score = cur_score;
      cmp_b       = best;
    end else if (!is_drain) begin
      cmp_a = best;
      cmp_b = cand;
    end
  end

  tksk_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_r)
  );

  always_comb begin
    scan_last = (CNT_W'(scan_idx) + CNT_W'(1)) == kept_count;
    // offer: cand is weaker than best; drain: cand ranks above best
    take      = (!is_drain || !emitted[scan_idx]) && (!have || cmp_r.above);
    load_last = empty_flag || ((rank + CNT_W'(1)) == kept_count);
  end

  // store writes: append while there is room, else replace the weakest if the offer scores strictly higher
  always_comb begin
    st_wr.en         = 1'b0;
    st_wr.addr       = best_idx;
    st_wr.data.key   = cur_key;
    st_wr.data.score = cur_score;
    if (state == S_PLACE && kept_count < keep_eff) begin
      st_wr.en   = 1'b1;
      st_wr.addr = kept_count[IDX_W-1:0];
    end else if (state == S_REPL && cmp_r.gt) begin
      st_wr.en = 1'b1;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= KEEP_RESET;
      hash_mode  <= 1'b0;
      hash_seed  <= SEED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEEP_COUNT: keep_count <= cfg_data[KEEP_W-1:0];
        REG_HASH_MODE:  hash_mode  <= cfg_data[0];
        REG_HASH_SEED:  hash_seed  <= cfg_data;
        default:        keep_count <= keep_count;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      kept_count <= '0;
      out_valid  <= 1'b0;
      have       <= 1'b0;
      rank       <= '0;
      emitted    <= '0;
      is_drain   <= 1'b0;
      empty_flag <= 1'b0;
      scan_idx   <= '0;
    end else begin
      scan_idx <= scan_idx_next;
      // output register: loaded by a rank, emptied by its transfer
      if (state == S_LOAD && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            is_drain   <= (kind == KIND_DRAIN);
            empty_flag <= (kind == KIND_DRAIN) && (kept_count == '0);
            have       <= 1'b0;
            rank       <= '0;
            emitted    <= '0;
            if (kind == KIND_DRAIN) begin
              state <= (kept_count == '0) ? S_LOAD : S_SCAN;
            end else if (keep_eff == '0) begin
              state <= S_IDLE;  // offers ignored
            end else if (hash_mode) begin
              state <= S_PREP;
            end else begin
              state <= S_PLACE;
            end
          end
        end
        S_PREP: state <= S_MUL1;
        S_MUL1: begin
          if (mrsp.done) begin
            state <= S_MUL2;
          end
        end
        S_MUL2: begin
          if (mrsp.done) begin
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          if (kept_count < keep_eff) begin
            kept_count <= kept_count + CNT_W'(1);
            state      <= S_IDLE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (take) begin
            have     <= 1'b1;
            best_idx <= scan_idx;
          end
          if (scan_last) begin
            state <= is_drain ? S_LOAD : S_REPL;
          end
        end
        S_REPL: state <= S_IDLE;
        S_LOAD: begin
          if (out_free) begin
            if (!empty_flag) begin
              emitted[best_idx] <= 1'b1;
              rank              <= rank + CNT_W'(1);
            end
            if (load_last) begin
              state <= S_IDLE;
            end else begin
              have  <= 1'b0;
              state <= S_SCAN;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cur_key   <= record_key;
      cur_score <= offer_score;
    end
    if (state == S_MUL2 && mrsp.done) begin
      cur_score <= hash_score;
    end
    if (state == S_SCAN && take) begin
      best <= cand;
    end
    if (state == S_LOAD && out_free) begin
      out_key   <= empty_flag ? '0 : best.key;
      out_score <= empty_flag ? '0 : best.score;
      out_empty <= empty_flag;
      out_last  <= load_last;
    end
  end

endmodule

// ----- hw/rtl/tksk_chk.sv -----
// ----------------------------------------------------------------------------
// tksk_chk
// port level checks of the top-k score keeper, bound to the top level
// ----------------------------------------------------------------------------
module tksk_chk
  import tksk_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      kind,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [KEY_W-1:0]          out_key,
  input logic signed [SCORE_W-1:0] out_score,
  input logic                      out_empty,
  input logic                      out_last
);

  // an empty drain is a single closing result
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_empty |-> out_last)
    else $error("empty result without last");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_empty |-> (out_key == '0) && (out_score == '0))
    else $error("empty result carries data");

  // a drain transfer always moves the sequencer out of idle, which drops ready
  a_drain_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (kind == KIND_DRAIN) |=> !in_ready)
    else $error("ready right after drain transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(out_last))
    else $error("stalled result changed");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind top_k_score_keeper_core tksk_chk u_tksk_chk (.*);

// ----- sim/top_k_score_keeper_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_k_score_keeper_core_test
// Self-checking bench for the streaming top-k keeper. Offers and drains are
// pushed through the valid/ready input. A scoreboard keeps its own copy of
// the kept store and registers, and turns every drain into the expected
// ranked entries. Each output transfer is checked in order, field by field.
// ----------------------------------------------------------------------------
module top_k_score_keeper_core_test;
  import tksk_pkg::*;

  // hash constants kept local so a wrong package value cannot hide
  localparam logic [KEY_W-1:0] GOLDEN        = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [KEY_W-1:0] MUL_A         = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [KEY_W-1:0] MUL_B         = 64'h94d0_49bb_1331_11eb;
  localparam logic [KEY_W-1:0] SEED_AT_RESET = 64'h3a5f_2d91_c7b0_4913;

  localparam logic signed [SCORE_W-1:0] SCORE_TOP    = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_BOTTOM = {1'b1, {(SCORE_W-1){1'b0}}};

  // worst offer is a full-store scan in hash mode, worst drain one store scan per rank
  localparam int QUIET_CYCLES = 40;
  localparam int TAIL_CYCLES  = 300;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
    logic               empty;
    logic               last;
  } ranked_t;

  // --------------------------------------------------------------------------
  // scoreboard: mirror of the kept store plus the queue of ranks still due
  // --------------------------------------------------------------------------
  class rank_board;
    logic [KEEP_W-1:0]         keep_reg;
    bit                        hash_on;
    logic [KEY_W-1:0]          seed;
    logic [KEY_W-1:0]          keys [CAPACITY];
    logic signed [SCORE_W-1:0] scores [CAPACITY];
    int                        held;
    ranked_t                   due_ranks [$];
    int                        errors;
    int                        checked;

    function new();
      keep_reg = 5'd16;
      hash_on  = 1'b0;
      seed     = SEED_AT_RESET;
      held     = 0;
      errors   = 0;
      checked  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_KEEP_COUNT: keep_reg = val[KEEP_W-1:0];
        REG_HASH_MODE:  hash_on  = val[0];
        REG_HASH_SEED:  seed     = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return due_ranks.size();
    endfunction

    // higher score wins, smaller key breaks a tie
    function bit outranks(logic signed [SCORE_W-1:0] sc_a, logic [KEY_W-1:0] k_a,
                          logic signed [SCORE_W-1:0] sc_b, logic [KEY_W-1:0] k_b);
      if (sc_a != sc_b) return sc_a > sc_b;
      return k_a < k_b;
    endfunction

    function int weakest_slot();
      int w;
      w = 0;
      for (int i = 1; i < held; i++)
        if (outranks(scores[w], keys[w], scores[i], keys[i])) w = i;
      return w;
    endfunction

    function logic signed [SCORE_W-1:0] weakest_score();
      if (held == 0) return '0;
      return scores[weakest_slot()];
    endfunction

    // seeded splitmix64, top 53 bits negated
    function logic signed [SCORE_W-1:0] hash_score(logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] v;
      v = (key ^ seed) + GOLDEN;
      v = (v ^ (v >> 30)) * MUL_A;
      v = (v ^ (v >> 27)) * MUL_B;
      v = v ^ (v >> 31);
      return -$signed({1'b0, v[KEY_W-1:11]});
    endfunction

    function void note_item(logic k, logic [KEY_W-1:0] key, logic signed [SCORE_W-1:0] sc);
      int                        limit;
      int                        w;
      int                        best;
      logic signed [SCORE_W-1:0] s;
      ranked_t                   r;
      bit                        taken [CAPACITY];
      if (k == KIND_OFFER) begin
        limit = (keep_reg > CAPACITY) ? CAPACITY : int'(keep_reg);
        if (limit == 0) return;
        s = hash_on ? hash_score(key) : sc;
        if (held < limit) begin
          keys[held]   = key;
          scores[held] = s;
          held++;
        end else begin
          w = weakest_slot();
          if (s > scores[w]) begin
            keys[w]   = key;
            scores[w] = s;
          end
        end
        return;
      end
      if (held == 0) begin
        r = '{key: '0, score: '0, empty: 1'b1, last: 1'b1};
        due_ranks.insert(due_ranks.size(), r);
        return;
      end
      foreach (taken[i]) taken[i] = 1'b0;
      for (int rank = 0; rank < held; rank++) begin
        best = -1;
        for (int i = 0; i < held; i++)
          if (!taken[i] && (best < 0 || outranks(scores[i], keys[i], scores[best], keys[best])))
            best = i;
        taken[best] = 1'b1;
        r.key   = keys[best];
        r.score = scores[best];
        r.empty = 1'b0;
        r.last  = (rank == held - 1);
        due_ranks.insert(due_ranks.size(), r);
      end
    endfunction

    task report(string msg);
      $display("MISMATCH %s", msg);
      errors++;
    endtask

    task check_rank(logic [KEY_W-1:0] got_key, logic [SCORE_W-1:0] got_score,
                    logic got_empty, logic got_last);
      ranked_t want;
      checked++;
      if (due_ranks.size() == 0) begin
        report($sformatf("unexpected result key %h score %h", got_key, got_score));
        return;
      end
      want = due_ranks.pop_front();
      if (got_key !== want.key)
        report($sformatf("out_key %h, expected %h", got_key, want.key));
      if (got_score !== want.score)
        report($sformatf("out_score %h, expected %h", got_score, want.score));
      if (got_empty !== want.empty)
        report($sformatf("out_empty %b, expected %b", got_empty, want.empty));
      if (got_last !== want.last)
        report($sformatf("out_last %b, expected %b", got_last, want.last));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // block and its wiring, every input known from time zero
  // --------------------------------------------------------------------------
  logic                      clk         = 1'b0;
  logic                      rst         = 1'b1;
  logic                      in_valid    = 1'b0;
  logic                      in_ready;
  logic                      kind        = KIND_OFFER;
  logic [KEY_W-1:0]          record_key  = '0;
  logic signed [SCORE_W-1:0] offer_score = '0;
  logic                      out_valid;
  logic                      out_ready   = 1'b0;
  logic [KEY_W-1:0]          out_key;
  logic signed [SCORE_W-1:0] out_score;
  logic                      out_empty;
  logic                      out_last;
  logic                      cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index   = '0;
  logic [CFG_DATA_W-1:0]     cfg_data    = '0;

  rank_board sb;

  // idle percentages for both sides, and a counter that asks for a long hold
  int send_idle = 23;
  int recv_idle = 67;
  int hold_req  = 0;

  int offers_sent = 0;
  int drains_sent = 0;
  int reg_writes  = 0;

  top_k_score_keeper_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .record_key (record_key),
    .offer_score(offer_score),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_key    (out_key),
    .out_score  (out_score),
    .out_empty  (out_empty),
    .out_last   (out_last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // run limit, well above the slowest legal run
  initial begin
    #2_000_000;
    $display("top_k_score_keeper_core test failed");
    $finish;
  end

  // receiver: random stalls, plus a long hold counted here when asked for
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  // every output transfer is checked against the oldest rank still due
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_rank(out_key, out_score, out_empty, out_last);
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // valid stays up between back-to-back items; it only drops for a gap
  task automatic send_item(logic k, logic [KEY_W-1:0] key, logic signed [SCORE_W-1:0] sc);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    record_key  <= key;
    offer_score <= sc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(k, key, sc);
    if (k == KIND_OFFER) offers_sent++;
    else drains_sent++;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 3))
      0:       return KEY_W'($urandom_range(0, 15));  // dense keys give score ties
      1:       return $urandom_range(0, 1) ? '1 : '0;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // scores aimed at the replacement boundary as well as the whole range
  function automatic logic signed [SCORE_W-1:0] pick_score();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? SCORE_TOP : SCORE_BOTTOM;
      1:       return sb.weakest_score();
      2:       return sb.weakest_score() + SCORE_W'(1);
      3, 4:    return SCORE_W'(signed'($urandom_range(0, 2000)) - 1000);
      default: return SCORE_W'({$urandom(), $urandom()});
    endcase
  endfunction

  task automatic offer(logic [KEY_W-1:0] key, logic signed [SCORE_W-1:0] sc);
    send_item(KIND_OFFER, key, sc);
  endtask

  // a drain still carries random payload, which the block must ignore
  task automatic drain();
    send_item(KIND_DRAIN, pick_key(), pick_score());
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // registers only change once the block has gone quiet
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_reg(idx, val);
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic settle();
    wait_results();
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // random offers with a drain now and then; optional pause mid-way
  task automatic run_mix(int count, int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) wait_results();
      if ($urandom_range(0, 99) < 15) drain();
      else offer(pick_key(), pick_score());
    end
    drain();
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int w;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: empty drain, then the field extremes
    drain();
    offer('0, SCORE_TOP);
    offer('1, SCORE_BOTTOM);
    offer(64'd5, '0);
    offer(64'd3, '0);
    drain();

    // keep count below what is held: nothing dropped, only replacements
    settle();
    write_reg(REG_KEEP_COUNT, 64'd2);
    offer(64'd9, '0);                 // displaces the bottom score
    offer(64'd7, '0);                 // ties the weakest score, rejected
    offer(64'd7, SCORE_W'(1));        // beats the weakest zero score, the one with the largest key
    drain();

    // zero keep count ignores offers, held entries stay
    settle();
    write_reg(REG_KEEP_COUNT, 64'd0);
    offer(64'd1, SCORE_TOP);
    drain();

    // keep count above capacity saturates, store fills to the top
    settle();
    write_reg(REG_KEEP_COUNT, 64'd31);
    for (int i = 0; i < 12; i++) offer(pick_key(), pick_score());
    drain();

    // hash scoring with the reset seed, with one pause for all results
    settle();
    write_reg(REG_HASH_MODE, 64'd1);
    run_mix(20, 10);

    // swap the idle pattern: mostly idle sender, mostly ready receiver
    send_idle = 67;
    recv_idle = 23;
    settle();
    write_reg(REG_HASH_SEED, '0);
    write_reg(REG_KEEP_COUNT, 64'd5);
    run_mix(20, -1);

    settle();
    write_reg(REG_HASH_SEED, '1);
    run_mix(20, -1);

    // no idling from here on
    send_idle = 0;
    recv_idle = 0;
    settle();
    write_reg(REG_HASH_SEED, {$urandom(), $urandom()});
    write_reg(REG_KEEP_COUNT, 64'd1);
    run_mix(20, -1);

    // long receiver hold while offers keep coming, so the input backs up
    settle();
    write_reg(REG_HASH_MODE, 64'd0);
    write_reg(REG_KEEP_COUNT, 64'd16);
    hold_req++;
    drain();
    run_mix(20, -1);

    // drain out, then give stray results time to show up
    in_valid <= 1'b0;
    for (w = 0; w < 50_000 && sb.pending() != 0; w++) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));

    $display("covered %0d offers and %0d drains across %0d register writes, %0d results checked",
             offers_sent, drains_sent, reg_writes, sb.checked);
    $display("included field extremes, weakest-entry ties, count saturation, hash seeds and stalls");
    if (sb.errors == 0) begin
      $display("top_k_score_keeper_core test passed");
    end else begin
      $display("top_k_score_keeper_core test failed");
    end
    $finish;
  end

endmodule
